// ===== rtl/tspt_pkg.sv =====
package tspt_pkg;

    // table geometry
    localparam int TABLE_ENTRIES  = 16;
    localparam int MAX_NAME_BYTES = 64;

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int IDX_W  = $clog2(MAX_NAME_BYTES);
    localparam int CNT_W  = $clog2(MAX_NAME_BYTES + 1);
    localparam int EADR_W = $clog2(TABLE_ENTRIES * MAX_NAME_BYTES);

    localparam logic [7:0] SEP_CHAR = 8'h2F;

    // commands carried on the input item
    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_MATCH  = 2'd3
    } t_op;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] name_byte;
        logic       byte_valid;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [6:0] match_length;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic wr_byte;    // input item accepted
        logic start;      // clear search results, slot 0
        logic slot_init;  // index 0, note free slot
        logic rd_walk;    // read name and entry at index
        logic step;       // index + 1
        logic rec_full;   // entry equals whole name
        logic rec_sep;    // entry is prefix if next name byte is separator
        logic next_slot;
        logic copy_init;
        logic copy_rd;
        logic copy_wr;
        logic finish;     // update table, load result, clear name
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ovf;
        logic skip;
        logic at_len;
        logic len_eq;
        logic byte_eq;
        logic slot_last;
        logic copy_needed;
        logic copy_done;
    } t_sts;

endpackage

// ===== rtl/tspt_ctrl.sv =====
module tspt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  tspt_pkg::t_sts i_sts,
    output tspt_pkg::t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_START = 9'b000000010,
        S_SLOT  = 9'b000000100,
        S_RD    = 9'b000001000,
        S_CMP   = 9'b000010000,
        S_NEXT  = 9'b000100000,
        S_CRD   = 9'b001000000,
        S_CWR   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc, out_acc, can_load;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_out_valid && !i_stall;
    assign can_load = !r_out_valid || !i_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.wr_byte = in_acc;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_last) n_state = S_START;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = i_sts.ovf ? S_FIN : S_SLOT;
            end
            S_SLOT: begin
                o_cmd.slot_init = 1'b1;
                n_state = i_sts.skip ? S_NEXT : S_RD;
            end
            S_RD: begin
                if (i_sts.at_len && i_sts.len_eq) begin
                    o_cmd.rec_full = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    o_cmd.rd_walk = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_sts.at_len) begin
                    if (i_sts.byte_eq) begin
                        o_cmd.step = 1'b1;
                        n_state = S_RD;
                    end else begin
                        n_state = S_NEXT;
                    end
                end else begin
                    o_cmd.rec_sep = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!i_sts.slot_last) begin
                    o_cmd.next_slot = 1'b1;
                    n_state = S_SLOT;
                end else if (i_sts.copy_needed) begin
                    o_cmd.copy_init = 1'b1;
                    n_state = S_CRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CRD: begin
                if (i_sts.copy_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.copy_rd = 1'b1;
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = S_CRD;
            end
            S_FIN: begin
                if (can_load) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_acc) n_out_valid = 1'b0;
        if (o_cmd.finish) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/tspt_dpath.sv =====
module tspt_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tspt_pkg::t_in_item  i_data,
    input  tspt_pkg::t_cmd      i_cmd,
    output tspt_pkg::t_sts      o_sts,
    output tspt_pkg::t_out_item o_data
);

    localparam int TE  = tspt_pkg::TABLE_ENTRIES;
    localparam int SW  = tspt_pkg::SLOT_W;
    localparam int IW  = tspt_pkg::IDX_W;
    localparam int CW  = tspt_pkg::CNT_W;
    localparam int EW  = tspt_pkg::EADR_W;
    localparam logic [CW-1:0] MAXB = CW'(tspt_pkg::MAX_NAME_BYTES);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TE - 1);

    // memories
    logic [7:0] name_mem  [tspt_pkg::MAX_NAME_BYTES];
    logic [7:0] entry_mem [TE * tspt_pkg::MAX_NAME_BYTES];

    logic [CW-1:0] r_len   [TE];
    logic [TE-1:0] r_valid;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    tspt_pkg::t_op r_op;

    logic [SW-1:0] r_slot;
    logic [CW-1:0] r_idx;
    logic [7:0]    r_nb, r_eb;

    logic          r_ex_found, r_free_found, r_any;
    logic [SW-1:0] r_ex_slot, r_free_slot, r_best_slot;
    logic [CW-1:0] r_ex_len, r_best_len;

    tspt_pkg::t_out_item r_out, n_out;

    logic [CW-1:0] cur_len;
    logic          cur_valid;
    logic [SW-1:0] addr_slot;
    logic [EW-1:0] eaddr;
    logic          sep;

    assign cur_len   = r_len[r_slot];
    assign cur_valid = r_valid[r_slot];
    assign addr_slot = i_cmd.copy_wr ? r_free_slot : r_slot;
    assign eaddr     = EW'(addr_slot) * EW'(tspt_pkg::MAX_NAME_BYTES) + EW'(r_idx[IW-1:0]);
    assign sep       = (r_nb == tspt_pkg::SEP_CHAR);

    // status
    always_comb begin
        o_sts.ovf         = r_ovf;
        o_sts.skip        = !cur_valid || (cur_len > r_count);
        o_sts.at_len      = (r_idx == cur_len);
        o_sts.len_eq      = (cur_len == r_count);
        o_sts.byte_eq     = (r_nb == r_eb);
        o_sts.slot_last   = (r_slot == LAST_SLOT);
        o_sts.copy_needed = (r_op == tspt_pkg::OP_ADD) && !r_ex_found && r_free_found
                            && (r_count != '0);
        o_sts.copy_done   = (r_idx == r_count);
    end

    assign o_data = r_out;

    // name buffer write and walk/copy reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte && i_data.byte_valid && (r_count < MAXB))
            name_mem[r_count[IW-1:0]] <= i_data.name_byte;
        if (i_cmd.rd_walk || i_cmd.copy_rd)
            r_nb <= name_mem[r_idx[IW-1:0]];
    end

    // entry contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_wr)
            entry_mem[eaddr] <= r_nb;
        if (i_cmd.rd_walk)
            r_eb <= entry_mem[eaddr];
    end

    // walk bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte && i_data.last)
            r_op <= tspt_pkg::t_op'(i_data.command);
        if (i_cmd.start) begin
            r_slot       <= '0;
            r_ex_found   <= 1'b0;
            r_free_found <= 1'b0;
            r_any        <= 1'b0;
        end
        if (i_cmd.slot_init) begin
            r_idx <= '0;
            if (!cur_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_slot;
            end
        end
        if (i_cmd.step || i_cmd.copy_wr)
            r_idx <= r_idx + CW'(1);
        if (i_cmd.copy_init)
            r_idx <= '0;
        if (i_cmd.next_slot)
            r_slot <= r_slot + SW'(1);
        if (i_cmd.rec_full && !r_ex_found) begin
            r_ex_found <= 1'b1;
            r_ex_slot  <= r_slot;
            r_ex_len   <= cur_len;
        end
        if ((i_cmd.rec_full || (i_cmd.rec_sep && sep)) && (!r_any || cur_len > r_best_len)) begin
            r_any       <= 1'b1;
            r_best_slot <= r_slot;
            r_best_len  <= cur_len;
        end
    end

    // result value
    always_comb begin
        n_out = '0;
        if (r_ovf) begin
            n_out.status = tspt_pkg::ST_TOO_LONG;
        end else begin
            unique case (r_op)
                tspt_pkg::OP_FIND, tspt_pkg::OP_REMOVE: begin
                    if (r_ex_found) begin
                        n_out.slot         = 4'(r_ex_slot);
                        n_out.match_length = 7'(r_ex_len);
                    end else begin
                        n_out.status = tspt_pkg::ST_NOT_FOUND;
                    end
                end
                tspt_pkg::OP_ADD: begin
                    if (r_ex_found) begin
                        n_out.status       = tspt_pkg::ST_PRESENT;
                        n_out.slot         = 4'(r_ex_slot);
                        n_out.match_length = 7'(r_ex_len);
                    end else if (r_free_found) begin
                        n_out.slot         = 4'(r_free_slot);
                        n_out.match_length = 7'(r_count);
                    end else begin
                        n_out.status = tspt_pkg::ST_FULL;
                    end
                end
                tspt_pkg::OP_MATCH: begin
                    if (r_any) begin
                        n_out.slot         = 4'(r_best_slot);
                        n_out.match_length = 7'(r_best_len);
                    end else begin
                        n_out.status = tspt_pkg::ST_NOT_FOUND;
                    end
                end
                default: n_out.status = tspt_pkg::ST_NOT_FOUND;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish)
            r_out <= n_out;
    end

    // table and name state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int i = 0; i < TE; i++) r_len[i] <= '0;
        end else begin
            if (i_cmd.wr_byte && i_data.byte_valid) begin
                if (r_count < MAXB) r_count <= r_count + CW'(1);
                else                r_ovf   <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                if (!r_ovf && r_op == tspt_pkg::OP_ADD && !r_ex_found && r_free_found) begin
                    r_valid[r_free_slot] <= 1'b1;
                    r_len[r_free_slot]   <= r_count;
                end
                if (!r_ovf && r_op == tspt_pkg::OP_REMOVE && r_ex_found)
                    r_valid[r_ex_slot] <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/topic_subscription_prefix_table.sv =====
// Subscription table for channel names with exact find, add, remove and
// longest directory-prefix match.
// Input channel: one name byte per item (i_data), with the command and a
// last flag; byte_valid = 0 lets an empty name or bare trigger through.
// Items without last are accepted whenever no walk is running and give no result.
// The item with last starts a walk over all 16 slots, unless the name is
// too long: each slot is checked, and for slots that are in use and no
// longer than the name the bytes are compared one by one (up to the entry
// length + 1); a successful add then copies the name into the free slot.
// One result item follows each last item on the output channel (o_data).
// The output register holds a result while i_stall is high; name bytes
// of the next command are still taken meanwhile, and the next walk waits
// at its end until the pending result is gone.
// Reset empties the name buffer and marks all slots free; entry contents
// are not cleared and need no clearing pass.
module topic_subscription_prefix_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tspt_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output tspt_pkg::t_out_item o_data
);

    tspt_pkg::t_cmd cmd;
    tspt_pkg::t_sts sts;

    tspt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_data.last),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tspt_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_data  (o_data)
    );

    // an accepted last item always blocks the input while its command runs
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.last) |=> o_stall)
        else $error("input not blocked after last item");

    // not-found, full and too-long results carry no slot or length
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status == tspt_pkg::ST_NOT_FOUND ||
                     o_data.status == tspt_pkg::ST_FULL ||
                     o_data.status == tspt_pkg::ST_TOO_LONG))
        |-> (o_data.slot == '0 && o_data.match_length == '0))
        else $error("failed result with nonzero slot or length");

    // stored lengths never exceed the buffer
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.match_length <= 7'(tspt_pkg::MAX_NAME_BYTES)))
        else $error("match length out of range");

endmodule
